// ===== rtl/bta_pkg.sv =====
`timescale 1ns / 1ps
package bta_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned CharW  = 7;
  localparam int unsigned MaxDig = 10;
  localparam int unsigned CntW   = 4;

  localparam logic [ModeW-1:0] MODE_DEC   = 2'd0;
  localparam logic [ModeW-1:0] MODE_HEX   = 2'd1;
  localparam logic [ModeW-1:0] MODE_FIXED = 2'd2;
  localparam logic [ModeW-1:0] MODE_NONE  = 2'd3;

  localparam logic [ValueW-1:0] FixLimit = 32'd10000;
  localparam logic [ValueW-1:0] Recip10  = 32'hCCCC_CCCD;
  localparam int unsigned       RecipSh  = 35;

  localparam logic [CharW-1:0] ChrZero  = 7'h30;
  localparam logic [CharW-1:0] ChrAlpha = 7'h40;
  localparam logic [CharW-1:0] ChrDot   = 7'h2E;
  localparam logic [CharW-1:0] ChrStar  = 7'h2A;

  localparam logic [CntW-1:0] FixLen    = 4'd5;
  localparam logic [CntW-1:0] FixLastCv = 4'd3;
  localparam logic [CntW-1:0] FixDotPos = 4'd1;
  localparam logic [CntW-1:0] FixTopDig = 4'd3;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_EMIT = 3'b100
  } state_e;

endpackage

// ===== rtl/bta_if.sv =====
`timescale 1ns / 1ps
interface bta_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [1:0]  mode;

  modport source (output valid, output value, output mode, input ready);
  modport sink   (input valid, input value, input mode, output ready);
endinterface

interface bta_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== rtl/binary_to_ascii_formatter.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Payload               Handshake
// in_i     in   value[31:0] mode[1:0] valid/ready
// out_o    out  character[6:0] last   valid/ready
//
// One conversion step per cycle: a divide-by-ten (reciprocal multiply) or a
// four-bit shift yields one digit. All digits are converted, then emitted one
// character per transfer (fixed mode: four digits, five characters; overflow
// skips conversion). Input ready is high only while idle; mode 3 leaves the
// block idle. Reset clears the sequencer and output valid. A stalled output
// holds the sequencer in the emit phase.
module binary_to_ascii_formatter
  import bta_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  bta_in_if.sink    in_i,
  bta_out_if.source out_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  logic [ValueW-1:0] v_q;
  logic              hex_q;
  logic              fix_q;
  logic              ovf_q;
  logic [CntW-1:0]   cnt_q;
  logic [CntW-1:0]   len_q;
  logic [CntW-1:0]   pos_q;
  logic [3:0]        dig_q [MaxDig];
  logic [CharW-1:0]  char_q;
  logic              last_q;

  logic              in_acc;
  logic [2*ValueW-1:0] prod;
  logic [ValueW-1:0] q10, q, rem10;
  logic [3:0]        r;
  logic              conv_done;
  logic              out_load;
  logic [CntW-1:0]   idx;
  logic [3:0]        dsel;
  logic [CharW-1:0]  dchr, char_d;
  logic              last_d;

  assign in_i.ready      = (state_q == S_IDLE);
  assign in_acc          = in_i.valid && in_i.ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.character = char_q;
  assign out_o.last      = last_q;

  assign prod  = {{ValueW{1'b0}}, v_q} * {{ValueW{1'b0}}, Recip10};
  assign q10   = {{RecipSh-ValueW{1'b0}}, prod[2*ValueW-1:RecipSh]};
  assign rem10 = v_q - ((q10 << 3) + (q10 << 1));
  assign q     = hex_q ? (v_q >> 4) : q10;
  assign r     = hex_q ? v_q[3:0] : rem10[3:0];
  assign conv_done = fix_q ? (cnt_q == FixLastCv) : (q == '0);

  assign out_load = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);

  always_comb begin
    if (fix_q || ovf_q) begin
      idx = (pos_q == '0) ? FixTopDig : (FixLen - 4'd1 - pos_q);
    end else begin
      idx = len_q - 4'd1 - pos_q;
    end
    dsel = dig_q[idx];
    if (dsel > 4'd9) begin
      dchr = ChrAlpha | {3'b000, dsel - 4'd9};
    end else begin
      dchr = ChrZero | {3'b000, dsel};
    end
    if ((fix_q || ovf_q) && pos_q == FixDotPos) begin
      char_d = ChrDot;
    end else if (ovf_q) begin
      char_d = ChrStar;
    end else begin
      char_d = dchr;
    end
    last_d = (pos_q == len_q - 4'd1);
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.mode inside {MODE_DEC, MODE_HEX}) begin
            state_d = S_CONV;
          end else if (in_i.mode == MODE_FIXED) begin
            state_d = (in_i.value >= FixLimit) ? S_EMIT : S_CONV;
          end
        end
      end
      S_CONV: begin
        if (conv_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load && last_d) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      v_q   <= in_i.value;
      hex_q <= (in_i.mode == MODE_HEX);
      fix_q <= (in_i.mode == MODE_FIXED);
      ovf_q <= (in_i.mode == MODE_FIXED) && (in_i.value >= FixLimit);
      cnt_q <= '0;
      pos_q <= '0;
      len_q <= FixLen;
    end
    if (state_q == S_CONV) begin
      dig_q[cnt_q] <= r;
      v_q          <= q;
      cnt_q        <= cnt_q + 4'd1;
      if (conv_done) begin
        len_q <= fix_q ? FixLen : (cnt_q + 4'd1);
      end
    end
    if (out_load) begin
      char_q <= char_d;
      last_q <= last_d;
      pos_q  <= pos_q + 4'd1;
    end
  end

  a_none_stays_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.mode == MODE_NONE) |=> in_i.ready)
    else $error("reserved mode left the block busy");

  a_item_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.mode != MODE_NONE) |=> !in_i.ready)
    else $error("block ready right after taking an item");

  a_mid_run_emitting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.last) |-> (state_q == S_EMIT))
    else $error("character run cut short");

endmodule

// ===== sim/binary_to_ascii_formatter_tb.sv =====
`timescale 1ns / 1ps
module binary_to_ascii_formatter_tb;
  import bta_pkg::*;

  localparam int StallLimit = 2000;
  localparam int RandomItems = 200;
  localparam int DrainCycles = 30;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic             last;
  } glyph_t;

  class char_ledger;
    glyph_t pending[$];
    int     mismatches;

    function new();
      mismatches = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    function int pending_count();
      return pending.size();
    endfunction

    // Render the expected character run for one accepted transaction.
    function void note_value(logic [ValueW-1:0] value, logic [ModeW-1:0] mode);
      logic [CharW-1:0]  text[$];
      logic [ValueW-1:0] rest;
      logic [3:0]        nib;
      glyph_t            g;
      rest = value;
      case (mode)
        MODE_DEC: begin
          do begin
            text.push_front(ChrZero | CharW'(rest % 10));
            rest = rest / 10;
          end while (rest != 0);
        end
        MODE_HEX: begin
          do begin
            nib = rest[3:0];
            text.push_front((nib > 9) ? (ChrAlpha | CharW'(nib - 9)) : (ChrZero | CharW'(nib)));
            rest = rest >> 4;
          end while (rest != 0);
        end
        MODE_FIXED: begin
          if (rest >= FixLimit) begin
            text = '{ChrStar, ChrDot, ChrStar, ChrStar, ChrStar};
          end else begin
            text.push_back(ChrZero | CharW'(rest / 1000));
            text.push_back(ChrDot);
            text.push_back(ChrZero | CharW'((rest % 1000) / 100));
            text.push_back(ChrZero | CharW'((rest % 100) / 10));
            text.push_back(ChrZero | CharW'(rest % 10));
          end
        end
        default: begin
        end
      endcase
      foreach (text[i]) begin
        g.character = text[i];
        g.last      = (i == text.size() - 1);
        pending.push_back(g);
      end
    endfunction

    task check_char(logic [CharW-1:0] character, logic last);
      glyph_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected char %h last %b", character, last));
      end else begin
        want = pending.pop_front();
        if (character !== want.character)
          report($sformatf("char got %h exp %h", character, want.character));
        if (last !== want.last)
          report($sformatf("last got %b exp %b (char %h)", last, want.last, want.character));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   idle_cycles = 0;

  char_ledger ledger;

  bta_in_if  in_if ();
  bta_out_if out_if ();

  binary_to_ascii_formatter dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [ValueW-1:0] pick_value();
    logic [63:0] p;
    int          k;
    p = 64'd1;
    case ($urandom_range(0, 4))
      0, 1: return $urandom;
      2: return $urandom_range(0, 20000);
      3: begin
        k = $urandom_range(0, 9);
        if ($urandom_range(0, 1) == 1) begin
          repeat (k) p = p * 10;
        end else begin
          p = p << (4 * (k % 8));
        end
        return ValueW'(p - $urandom_range(0, 1));
      end
      default: return $urandom_range(9000, 11000);
    endcase
  endfunction

  function automatic logic [ModeW-1:0] pick_mode();
    int r;
    r = $urandom_range(0, 9);
    if (r == 9) return MODE_NONE;
    if (r < 3) return MODE_DEC;
    if (r < 6) return MODE_HEX;
    return MODE_FIXED;
  endfunction

  task automatic send_value(input logic [ValueW-1:0] v, input logic [ModeW-1:0] m);
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.value <= v;
    in_if.mode  <= m;
    do @(posedge clk); while (!in_if.ready);
    ledger.note_value(v, m);
  endtask

  task automatic hold_sender(input int cycles);
    @(negedge clk);
    in_if.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (ledger.pending_count() != 0) @(negedge clk);
  endtask

  // Receiver: rotate through four ready patterns.
  initial begin
    int phase_cycle;
    phase_cycle = 0;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      phase_cycle++;
      case ((phase_cycle / 50) % 4)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 1) == 1);
        2: out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= ((phase_cycle % 7) < 2);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      ledger.check_char(out_if.character, out_if.last);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [ValueW-1:0] dir_value[$];
    logic [ModeW-1:0]  dir_mode[$];
    logic [ValueW-1:0] v;
    logic [ModeW-1:0]  m;
    int                rendered;
    int                burst;
    bit                paused;
    ledger = new();
    in_if.valid = 1'b0;
    in_if.value = '0;
    in_if.mode  = MODE_DEC;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    dir_value = '{32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'd9, 32'd10, 32'd1000000000, 32'd999999999, 32'hF, 32'h10,
                  32'hABCD_EF09, 32'h1000_0000, 32'd9999, 32'd10000, 32'd1000,
                  32'd7, 32'h1234_5678, 32'd0, 32'h5A5A_5A5A, 32'hA5A5_A5A5};
    dir_mode  = '{MODE_DEC, MODE_HEX, MODE_FIXED, MODE_DEC, MODE_HEX, MODE_FIXED,
                  MODE_DEC, MODE_DEC, MODE_DEC, MODE_DEC, MODE_HEX, MODE_HEX,
                  MODE_HEX, MODE_HEX, MODE_FIXED, MODE_FIXED, MODE_FIXED,
                  MODE_FIXED, MODE_NONE, MODE_NONE, MODE_DEC, MODE_HEX};
    foreach (dir_value[i]) begin
      send_value(dir_value[i], dir_mode[i]);
      if (i % 5 == 4) hold_sender($urandom_range(0, 6));
    end

    rendered = 0;
    burst    = 0;
    paused   = 1'b0;
    while (rendered < RandomItems) begin
      if (!paused && rendered >= RandomItems / 2) begin
        drain_results();
        paused = 1'b1;
      end
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        if ($urandom_range(0, 3) != 0) hold_sender($urandom_range(0, 25));
      end
      burst--;
      m = pick_mode();
      v = pick_value();
      send_value(v, m);
      rendered++;
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk);
    if (ledger.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bta_pkg.sv
rtl/bta_if.sv
rtl/binary_to_ascii_formatter.sv
sim/binary_to_ascii_formatter_tb.sv
